// File: sv/logical_immediate_encoder_macros.svh
// Assertion macros shared by the encoder checker
`ifndef LOGICAL_IMMEDIATE_ENCODER_MACROS_SVH
`define LOGICAL_IMMEDIATE_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low
`define LIE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("logical immediate encoder check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low
`define LIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("logical immediate encoder check failed");

`endif

// File: sv/lie_pkg.sv
// Types, constants and helper functions for the logical immediate encoder
`default_nettype none

package lie_pkg;

    // One-hot element size: bit k set means an element of 2^(k+1) bits
    typedef logic [5:0] t_size;
    typedef logic [6:0] t_count;

    localparam t_size SZ2  = 6'b000001;
    localparam t_size SZ4  = 6'b000010;
    localparam t_size SZ8  = 6'b000100;
    localparam t_size SZ16 = 6'b001000;
    localparam t_size SZ32 = 6'b010000;
    localparam t_size SZ64 = 6'b100000;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_count      TWO_EDGES = 7'd2;

    function automatic t_count size_val(input t_size sz);
        t_count v;
        unique case (sz)
            SZ2:     v = 7'd2;
            SZ4:     v = 7'd4;
            SZ8:     v = 7'd8;
            SZ16:    v = 7'd16;
            SZ32:    v = 7'd32;
            SZ64:    v = 7'd64;
            default: v = 7'd64;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] elem_mask(input t_size sz);
        logic [63:0] m;
        unique case (sz)
            SZ2:     m = 64'h3;
            SZ4:     m = 64'hF;
            SZ8:     m = 64'hFF;
            SZ16:    m = 64'hFFFF;
            SZ32:    m = 64'hFFFF_FFFF;
            SZ64:    m = ALL_ONES;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

    // Bit j marks a change between element bits j and j+1, wrapping at the element top
    function automatic logic [63:0] edges(input logic [63:0] e, input t_size sz);
        logic [63:0] t;
        t = e ^ (e >> 1);
        unique case (sz)
            SZ2:     t[1]  = e[1]  ^ e[0];
            SZ4:     t[3]  = e[3]  ^ e[0];
            SZ8:     t[7]  = e[7]  ^ e[0];
            SZ16:    t[15] = e[15] ^ e[0];
            SZ32:    t[31] = e[31] ^ e[0];
            SZ64:    t[63] = e[63] ^ e[0];
            default: t[63] = e[63] ^ e[0];
        endcase
        return t;
    endfunction

    // Balanced adder tree: pairs, then nibbles, bytes, and so on
    function automatic t_count popcnt64(input logic [63:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int j = 0; j < 32; j++) begin
            s1[j] = {1'b0, v[2*j]} + {1'b0, v[2*j+1]};
        end
        for (int j = 0; j < 16; j++) begin
            s2[j] = {1'b0, s1[2*j]} + {1'b0, s1[2*j+1]};
        end
        for (int j = 0; j < 8; j++) begin
            s3[j] = {1'b0, s2[2*j]} + {1'b0, s2[2*j+1]};
        end
        for (int j = 0; j < 4; j++) begin
            s4[j] = {1'b0, s3[2*j]} + {1'b0, s3[2*j+1]};
        end
        for (int j = 0; j < 2; j++) begin
            s5[j] = {1'b0, s4[2*j]} + {1'b0, s4[2*j+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

    // Incrementing flips the trailing ones and the first zero above them
    function automatic t_count trail_ones(input logic [63:0] v);
        logic [64:0] inc;
        logic [64:0] flips;
        inc   = {1'b0, v} + 65'd1;
        flips = {1'b0, v} ^ inc;
        return popcnt64(flips[64:1]);
    endfunction

    function automatic t_count trail_zeros(input logic [63:0] v);
        return trail_ones(~v);
    endfunction

endpackage

`default_nettype wire

// File: sv/logical_immediate_encoder.sv
// Logical immediate encoder: four-stage pipeline from immediate to N:immr:imms
//
// Input channel: i_in_valid / o_in_ready carry i_immediate (64 bits) and
// i_reg_is_64 (1 = 64-bit register, 0 = 32-bit). Output channel:
// o_out_valid / i_out_ready carry o_encodable and the 13-bit o_encoding
// (N in bit 12, immr in 11:6, imms in 5:0; zero when not encodable).
// One result per transaction, in order.
//
// An accepted transaction is registered in stage 1 and then passes through
// stages 2, 3 and 4 to the output. Throughput is one transaction per cycle
// while results are taken; the stages are input capture, element size and
// exclusion checks, bit counting over the element, and encoding assembly.
//
// Reset (i_rst_n low at a clock edge) empties every stage. When the receiver
// holds i_out_ready low, the output stage holds its result and each stage
// keeps accepting until the stage ahead of it is full, so o_in_ready drops
// only when all four stages hold a transaction.
`default_nettype none

module logical_immediate_encoder
    import lie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_immediate,
    input  wire logic        i_reg_is_64,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_encodable,
    output logic [12:0]      o_encoding
);

    // stage registers
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [63:0] r_imm1;
    logic        r_r64_1;
    logic        r_excl2;
    t_size       r_size2;
    logic [63:0] r_elem2;
    logic        r_excl3;
    t_size       r_size3;
    t_count      r_nedge3, r_cto3, r_to3, r_tz3;
    logic        r_e0_3;
    logic        r_enc4;
    logic [12:0] r_code4;

    logic rdy1, rdy2, rdy3, rdy4;

    // stage 2 next values
    logic        n_excl2;
    t_size       n_size2;
    logic        eq32, eq16, eq8, eq4, eq2;

    // stage 4 next values
    logic        n_enc4;
    logic [12:0] n_code4;
    t_count      sz_v, immr_v, nimms_v;

    assign rdy4 = !r_v4 || i_out_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_ready = rdy1;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: capture the transaction
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_imm1  <= i_immediate;
            r_r64_1 <= i_reg_is_64;
        end
    end

    // stage 2: excluded values and smallest repeating element
    always_comb begin
        n_excl2 = (r_imm1 == 64'd0) || (r_imm1 == ALL_ONES) ||
                  (!r_r64_1 && ((r_imm1[63:32] != 32'd0) ||
                                (r_imm1[31:0] == 32'hFFFF_FFFF)));
        eq32 = r_imm1[31:0]  == r_imm1[63:32];
        eq16 = r_imm1[15:0]  == r_imm1[31:16];
        eq8  = r_imm1[7:0]   == r_imm1[15:8];
        eq4  = r_imm1[3:0]   == r_imm1[7:4];
        eq2  = r_imm1[1:0]   == r_imm1[3:2];
        priority if (r_r64_1 && !eq32) n_size2 = SZ64;
        else if (!eq16)                n_size2 = SZ32;
        else if (!eq8)                 n_size2 = SZ16;
        else if (!eq4)                 n_size2 = SZ8;
        else if (!eq2)                 n_size2 = SZ4;
        else                           n_size2 = SZ2;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_excl2 <= n_excl2;
            r_size2 <= n_size2;
            r_elem2 <= r_imm1 & elem_mask(n_size2);
        end
    end

    // stage 3: count edges, ones, trailing ones and trailing zeros of the element
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_excl3  <= r_excl2;
            r_size3  <= r_size2;
            r_nedge3 <= popcnt64(edges(r_elem2, r_size2));
            r_cto3   <= popcnt64(r_elem2);
            r_to3    <= trail_ones(r_elem2);
            r_tz3    <= trail_zeros(r_elem2);
            r_e0_3   <= r_elem2[0];
        end
    end

    // stage 4: a rotated run has exactly two bit transitions around the element
    always_comb begin
        sz_v    = size_val(r_size3);
        n_enc4  = !r_excl3 && (r_nedge3 == TWO_EDGES);
        immr_v  = (r_e0_3 ? (r_cto3 - r_to3) : (sz_v - r_tz3)) & (sz_v - 7'd1);
        nimms_v = ((~(sz_v - 7'd1)) << 1) | (r_cto3 - 7'd1);
        n_code4 = n_enc4 ? {~nimms_v[6], immr_v[5:0], nimms_v[5:0]} : 13'd0;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_enc4  <= n_enc4;
            r_code4 <= n_code4;
        end
    end

    assign o_out_valid = r_v4;
    assign o_encodable = r_enc4;
    assign o_encoding  = r_code4;

endmodule

`default_nettype wire

// File: sv/lie_checker.sv
// Port-level checker for the logical immediate encoder, bound to the top level
`default_nettype none

`include "logical_immediate_encoder_macros.svh"

module lie_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_encodable,
    input wire logic [12:0] o_encoding
);

    // a rejected value carries no encoding
    `LIE_ASSERT_NOW(a_zero_when_rejected, o_out_valid && !o_encodable, o_encoding == 13'd0)

    // a 64-bit element never has all 64 bits in its run
    `LIE_ASSERT_NOW(a_n_run_short, o_out_valid && o_encodable && o_encoding[12],
        o_encoding[5:0] != 6'h3F)

    // a smaller element leaves at least one size bit clear in imms
    `LIE_ASSERT_NOW(a_small_elem_imms, o_out_valid && o_encodable && !o_encoding[12],
        o_encoding[5:1] != 5'h1F)

    // hold a stalled result
    `LIE_ASSERT_NEXT(a_hold_stalled, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_encoding) && $stable(o_encodable))

endmodule

bind logical_immediate_encoder lie_checker u_lie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_encodable (o_encodable),
    .o_encoding  (o_encoding)
);

`default_nettype wire
